FILE: design/rfq_pkg.sv
`default_nettype none
package rfq_pkg;

  // Item opcodes
  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_TICK = 2'd1,
    OP_MODE = 2'd2,
    OP_READ = 2'd3
  } opcode_e;

  // Channel events
  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_VALIDATED = 3'd1,
    EV_INVALID   = 3'd2,
    EV_BTN_A     = 3'd3,
    EV_BTN_B     = 3'd4,
    EV_BTN_C     = 3'd5,
    EV_BTN_D     = 3'd6,
    EV_UNKNOWN   = 3'd7
  } event_e;

  // Configuration register indexes (paddr[2])
  localparam logic REG_MIN_SAMPLES     = 1'b0;
  localparam logic REG_RELEASE_TIMEOUT = 1'b1;

  localparam logic [7:0]  MIN_SAMPLES_RST     = 8'd20;
  localparam logic [15:0] RELEASE_TIMEOUT_RST = 16'd80;
  localparam logic [7:0]  COUNT_MAX           = 8'hFF;

  typedef struct packed {
    opcode_e     opcode;
    logic [1:0]  channel;
    logic [31:0] rx_code;
    logic [31:0] now_ms;
    logic        learn_request;
  } item_t;

  typedef struct packed {
    event_e      event_res;
    logic [7:0]  sample_count;
    logic [31:0] held_code;
    logic        learn_mode;
  } result_t;

  // Map the low nibble of a held code to a button event
  function automatic event_e button_event(input logic [31:0] code);
    event_e ev;
    case (code[3:0])
      4'h1:    ev = EV_BTN_A;
      4'h2:    ev = EV_BTN_B;
      4'h4:    ev = EV_BTN_C;
      4'h8:    ev = EV_BTN_D;
      default: ev = EV_UNKNOWN;
    endcase
    return ev;
  endfunction

endpackage
`default_nettype wire

FILE: design/rf_remote_code_qualifier.sv
// RF remote code qualifier.
// Requests arrive on the in_ channel (valid/stall) with an opcode, a channel,
// a code word, the millisecond time and a learn flag; each request yields
// exactly one result on the out_ channel (event, count, held code, mode).
// A request is taken into an input register, processed against the addressed
// channel's state combinationally and lands in the result register; while the
// receiver does not stall, one request is taken every cycle. The input
// register and the result register decouple the sides, so a new request is
// accepted while a finished result still waits.
// When the receiver stalls, the result holds; the input side stalls only once
// the input register is also occupied.
// Reset clears all channels to idle with zero count, code, time and event,
// selects normal mode and loads min_samples = 20, release_timeout_ms = 80.
// The APB port holds min_samples at 0x0 and release_timeout_ms at 0x4; write
// it only while no request is in flight. pready is always high.
`default_nettype none
module rf_remote_code_qualifier
  import rfq_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // request channel
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  opcode_i,
  input  wire logic [1:0]  channel_i,
  input  wire logic [31:0] rx_code_i,
  input  wire logic [31:0] now_ms_i,
  input  wire logic        learn_request_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       event_res_o,
  output logic [7:0]       sample_count_o,
  output logic [31:0]      held_code_o,
  output logic             learn_mode_o,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0]  min_samples_q;
  logic [15:0] release_timeout_q;
  logic        cfg_write;

  item_t   in_item;
  item_t   stage_item;
  logic    stage_valid;
  logic    advance;
  result_t core_result;
  result_t result_q;
  logic    out_valid_q, out_valid_d;

  // Configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_samples_q     <= MIN_SAMPLES_RST;
      release_timeout_q <= RELEASE_TIMEOUT_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_MIN_SAMPLES:     min_samples_q     <= pwdata[7:0];
        REG_RELEASE_TIMEOUT: release_timeout_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MIN_SAMPLES:     prdata = {24'd0, min_samples_q};
      REG_RELEASE_TIMEOUT: prdata = {16'd0, release_timeout_q};
      default:             prdata = '0;
    endcase
  end

  // Pack the request fields
  assign in_item.opcode        = opcode_e'(opcode_i);
  assign in_item.channel       = channel_i;
  assign in_item.rx_code       = rx_code_i;
  assign in_item.now_ms        = now_ms_i;
  assign in_item.learn_request = learn_request_i;

  // Move on whenever the result register is free or being drained
  assign advance = stage_valid & (~out_valid_q | ~out_stall_i);

  rfq_in_stage u_in_stage (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .item_i        (in_item),
    .advance_i     (advance),
    .stage_valid_o (stage_valid),
    .item_o        (stage_item)
  );

  rfq_core #(
    .NumChannels (NUM_CHANNELS)
  ) u_core (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .fire_i            (advance),
    .item_i            (stage_item),
    .min_samples_i     (min_samples_q),
    .release_timeout_i (release_timeout_q),
    .result_o          (core_result)
  );

  // Result register
  assign out_valid_d = advance | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      result_q <= core_result;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = result_q.event_res;
  assign sample_count_o = result_q.sample_count;
  assign held_code_o    = result_q.held_code;
  assign learn_mode_o   = result_q.learn_mode;

  // Checks
  a_stall_needs_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (stage_valid && out_valid_q && out_stall_i))
    else $error("input stalls without a blocked request");

  a_mode_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && stage_item.opcode == OP_MODE)
      |=> (learn_mode_o == $past(stage_item.learn_request)))
    else $error("set-mode result does not show the requested mode");

  a_event_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && stage_item.opcode != OP_READ) |=> (event_res_o == EV_NONE))
    else $error("event reported for a request that does not read it");

  a_bad_channel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (32'(stage_item.channel) >= 32'(NUM_CHANNELS)))
      |=> (sample_count_o == 8'd0 && held_code_o == 32'd0))
    else $error("unmapped channel returns channel state");

  a_result_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_o)
    else $error("processed request left no result");

endmodule
`default_nettype wire

FILE: design/rfq_in_stage.sv
`default_nettype none
module rfq_in_stage
  import rfq_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  input  wire item_t item_i,
  input  wire logic  advance_i,
  output logic       stage_valid_o,
  output item_t      item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  // Stall only while a held request cannot move on
  assign in_stall_o = valid_q & ~advance_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign valid_d    = accept | (valid_q & ~advance_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the request payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign stage_valid_o = valid_q;
  assign item_o        = item_q;

endmodule
`default_nettype wire

FILE: design/rfq_core.sv
`default_nettype none
module rfq_core
  import rfq_pkg::*;
#(
  parameter int unsigned NumChannels = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        fire_i,
  input  wire item_t       item_i,
  input  wire logic [7:0]  min_samples_i,
  input  wire logic [15:0] release_timeout_i,
  output result_t          result_o
);

  logic        flag_q [NumChannels];
  logic [7:0]  cnt_q  [NumChannels];
  logic [31:0] ref_q  [NumChannels];
  logic [31:0] last_q [NumChannels];
  event_e      pend_q [NumChannels];
  logic        learn_q;

  logic        ch_valid;
  logic        sel_flag;
  logic [7:0]  sel_cnt;
  logic [31:0] sel_ref;
  logic [31:0] sel_last;
  event_e      sel_pend;

  logic        flag_n;
  logic [7:0]  cnt_n;
  logic [31:0] ref_n;
  logic [31:0] last_n;
  event_e      pend_n;
  logic        learn_n;
  event_e      ev_out;
  logic [31:0] elapsed;

  assign ch_valid = 32'(item_i.channel) < 32'(NumChannels);
  assign elapsed  = item_i.now_ms - sel_last;

  // Select the addressed channel's state
  always_comb begin
    sel_flag = 1'b0;
    sel_cnt  = '0;
    sel_ref  = '0;
    sel_last = '0;
    sel_pend = EV_NONE;
    for (int i = 0; i < NumChannels; i++) begin
      if (32'(item_i.channel) == 32'(i)) begin
        sel_flag = flag_q[i];
        sel_cnt  = cnt_q[i];
        sel_ref  = ref_q[i];
        sel_last = last_q[i];
        sel_pend = pend_q[i];
      end
    end
  end

  // Next channel state and mode for the current request
  always_comb begin
    flag_n  = sel_flag;
    cnt_n   = sel_cnt;
    ref_n   = sel_ref;
    last_n  = sel_last;
    pend_n  = sel_pend;
    learn_n = learn_q;
    ev_out  = EV_NONE;
    case (item_i.opcode)
      OP_RX: begin
        if (ch_valid) begin
          last_n = item_i.now_ms;
          if (!sel_flag) begin
            ref_n  = item_i.rx_code;
            cnt_n  = 8'd1;
            flag_n = 1'b1;
          end else if (item_i.rx_code == sel_ref) begin
            if (sel_cnt != COUNT_MAX) begin
              cnt_n = sel_cnt + 8'd1;
            end
          end else begin
            cnt_n   = '0;
            ref_n   = '0;
            flag_n  = 1'b0;
            pend_n  = EV_INVALID;
            learn_n = 1'b0;
          end
          // Enough repeats in learn mode validate the code
          if (learn_n && (cnt_n > min_samples_i)) begin
            pend_n  = EV_VALIDATED;
            learn_n = 1'b0;
          end
        end
      end
      OP_TICK: begin
        if (ch_valid && !learn_q && sel_flag &&
            (elapsed > {16'd0, release_timeout_i})) begin
          pend_n = button_event(sel_ref);
          cnt_n  = '0;
          flag_n = 1'b0;
        end
      end
      OP_MODE: begin
        cnt_n   = '0;
        learn_n = item_i.learn_request;
      end
      OP_READ: begin
        if (ch_valid) begin
          ev_out = sel_pend;
          pend_n = EV_NONE;
        end
      end
      default: ;
    endcase
  end

  // Write back the addressed channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        flag_q[i] <= 1'b0;
        cnt_q[i]  <= '0;
        ref_q[i]  <= '0;
        last_q[i] <= '0;
        pend_q[i] <= EV_NONE;
      end
      learn_q <= 1'b0;
    end else if (fire_i) begin
      for (int i = 0; i < NumChannels; i++) begin
        if (ch_valid && (32'(item_i.channel) == 32'(i))) begin
          flag_q[i] <= flag_n;
          cnt_q[i]  <= cnt_n;
          ref_q[i]  <= ref_n;
          last_q[i] <= last_n;
          pend_q[i] <= pend_n;
        end
      end
      learn_q <= learn_n;
    end
  end

  // Result of the request
  assign result_o.event_res    = ev_out;
  assign result_o.sample_count = ch_valid ? cnt_n : 8'd0;
  assign result_o.held_code    = ch_valid ? ref_n : 32'd0;
  assign result_o.learn_mode   = learn_n;

endmodule
`default_nettype wire

FILE: test/rfq_checker.sv
`timescale 1ns / 100ps
module rfq_checker
  import rfq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // request channel
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  opcode_i,
  input  logic [1:0]  channel_i,
  input  logic [31:0] rx_code_i,
  input  logic [31:0] now_ms_i,
  input  logic        learn_request_i,
  // result channel
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  event_res_i,
  input  logic [7:0]  sample_count_i,
  input  logic [31:0] held_code_i,
  input  logic        learn_mode_i,
  // configuration port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  // status toward the stimulus side
  output int          pending_o,
  output int          errors_o
);

  localparam int         NCH               = 4;
  localparam logic [7:0]  MIN_SAMPLES_INIT  = 8'd20;
  localparam logic [15:0] TIMEOUT_INIT      = 16'd80;
  localparam logic [7:0]  COUNT_CEILING     = 8'hFF;

  // Shadow configuration and channel state
  logic [7:0]  min_samples_q;
  logic [15:0] timeout_q;
  logic        busy_q     [NCH];
  logic [7:0]  count_q    [NCH];
  logic [31:0] ref_code_q [NCH];
  logic [31:0] last_ms_q  [NCH];
  event_e      ev_slot_q  [NCH];
  logic        learn_q;

  result_t     expected_results[$];
  int          mismatches = 0;
  item_t       seen_req;
  result_t     new_res;
  result_t     want_res;

  // Print one line per mismatch and count it
  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    $display("%0t checker: %s got %0h, expected %0h", $time, what, got, want);
  endtask

  function automatic event_e decode_button(input logic [31:0] code);
    event_e ev;
    unique case (code[3:0])
      4'h1:    ev = EV_BTN_A;
      4'h2:    ev = EV_BTN_B;
      4'h4:    ev = EV_BTN_C;
      4'h8:    ev = EV_BTN_D;
      default: ev = EV_UNKNOWN;
    endcase
    return ev;
  endfunction

  // Apply one request to the shadow state and form its result
  task automatic qualify_request(input item_t req, output result_t res);
    logic [1:0]  c;
    logic [31:0] elapsed;
    event_e      taken;
    c     = req.channel;
    taken = EV_NONE;
    case (req.opcode)
      OP_MODE: begin
        count_q[c] = 8'd0;
        learn_q    = req.learn_request;
      end
      OP_RX: begin
        last_ms_q[c] = req.now_ms;
        if (!busy_q[c]) begin
          ref_code_q[c] = req.rx_code;
          count_q[c]    = 8'd1;
          busy_q[c]     = 1'b1;
        end else if (req.rx_code == ref_code_q[c]) begin
          if (count_q[c] != COUNT_CEILING) count_q[c] = count_q[c] + 8'd1;
        end else begin
          count_q[c]    = 8'd0;
          ref_code_q[c] = 32'd0;
          busy_q[c]     = 1'b0;
          ev_slot_q[c]  = EV_INVALID;
          learn_q       = 1'b0;
        end
        if (learn_q && count_q[c] > min_samples_q) begin
          ev_slot_q[c] = EV_VALIDATED;
          learn_q      = 1'b0;
        end
      end
      OP_TICK: begin
        elapsed = req.now_ms - last_ms_q[c];
        if (!learn_q && busy_q[c] && elapsed > {16'd0, timeout_q}) begin
          ev_slot_q[c] = decode_button(ref_code_q[c]);
          count_q[c]   = 8'd0;
          busy_q[c]    = 1'b0;
        end
      end
      default: begin
        taken        = ev_slot_q[c];
        ev_slot_q[c] = EV_NONE;
      end
    endcase
    res.event_res    = taken;
    res.sample_count = count_q[c];
    res.held_code    = ref_code_q[c];
    res.learn_mode   = learn_q;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_samples_q = MIN_SAMPLES_INIT;
      timeout_q     = TIMEOUT_INIT;
      learn_q       = 1'b0;
      for (int i = 0; i < NCH; i++) begin
        busy_q[i]     = 1'b0;
        count_q[i]    = 8'd0;
        ref_code_q[i] = 32'd0;
        last_ms_q[i]  = 32'd0;
        ev_slot_q[i]  = EV_NONE;
      end
      expected_results.delete();
      pending_o <= 0;
      errors_o  <= mismatches;
    end else begin
      // Compare a delivered result with the oldest expectation
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          note_mismatch("result with nothing outstanding", held_code_i, 32'd0);
        end else begin
          want_res = expected_results.pop_front();
          if (event_res_i != want_res.event_res)
            note_mismatch("event_res", 32'(event_res_i), 32'(want_res.event_res));
          if (sample_count_i != want_res.sample_count)
            note_mismatch("sample_count", 32'(sample_count_i),
                          32'(want_res.sample_count));
          if (held_code_i != want_res.held_code)
            note_mismatch("held_code", held_code_i, want_res.held_code);
          if (learn_mode_i != want_res.learn_mode)
            note_mismatch("learn_mode", 32'(learn_mode_i), 32'(want_res.learn_mode));
        end
      end
      // Predict an accepted request
      if (in_valid_i && !in_stall_i) begin
        seen_req.opcode        = opcode_e'(opcode_i);
        seen_req.channel       = channel_i;
        seen_req.rx_code       = rx_code_i;
        seen_req.now_ms        = now_ms_i;
        seen_req.learn_request = learn_request_i;
        qualify_request(seen_req, new_res);
        expected_results.push_back(new_res);
      end
      // Track register writes
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[2])
          REG_MIN_SAMPLES:     min_samples_q = pwdata_i[7:0];
          REG_RELEASE_TIMEOUT: timeout_q     = pwdata_i[15:0];
          default: ;
        endcase
      end
      pending_o <= expected_results.size();
      errors_o  <= mismatches;
    end
  end

endmodule

FILE: test/tb_rf_remote_code_qualifier.sv
`timescale 1ns / 100ps
module tb_rf_remote_code_qualifier;
  import rfq_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_ITEMS  = 150;
  localparam int DRAIN_CYCLES = 8;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        in_valid_i      = 1'b0;
  logic        in_stall_o;
  logic [1:0]  opcode_i        = 2'd0;
  logic [1:0]  channel_i       = 2'd0;
  logic [31:0] rx_code_i       = 32'd0;
  logic [31:0] now_ms_i        = 32'd0;
  logic        learn_request_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i     = 1'b0;
  logic [2:0]  event_res_o;
  logic [7:0]  sample_count_o;
  logic [31:0] held_code_o;
  logic        learn_mode_o;
  logic        psel            = 1'b0;
  logic        penable         = 1'b0;
  logic        pwrite          = 1'b0;
  logic [2:0]  paddr           = 3'd0;
  logic [31:0] pwdata          = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  int          pending_count;
  int          fail_count;
  int          cycles    = 0;
  int          gap_pct   = 0;
  int          stall_pct = 0;
  int          sent      = 0;
  logic [7:0]  cur_min     = 8'd20;
  logic [15:0] cur_timeout = 16'd80;
  logic [31:0] ms_now      = 32'd0;

  rf_remote_code_qualifier u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .channel_i      (channel_i),
    .rx_code_i      (rx_code_i),
    .now_ms_i       (now_ms_i),
    .learn_request_i(learn_request_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_o    (event_res_o),
    .sample_count_o (sample_count_o),
    .held_code_o    (held_code_o),
    .learn_mode_o   (learn_mode_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  rfq_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .opcode_i       (opcode_i),
    .channel_i      (channel_i),
    .rx_code_i      (rx_code_i),
    .now_ms_i       (now_ms_i),
    .learn_request_i(learn_request_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .event_res_i    (event_res_o),
    .sample_count_i (sample_count_o),
    .held_code_i    (held_code_o),
    .learn_mode_i   (learn_mode_o),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .pending_o      (pending_count),
    .errors_o       (fail_count)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stall the result side at random
  always @(posedge clk_i) begin
    out_stall_i <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("rf_remote_code_qualifier: mismatch");
      $finish;
    end
  end

  // Offer one request, idling first at random, and hold it until taken
  task automatic send_request(input opcode_e op, input logic [1:0] ch,
                              input logic [31:0] code, input logic [31:0] ms,
                              input logic learn);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    opcode_i        <= op;
    channel_i       <= ch;
    rx_code_i       <= code;
    now_ms_i        <= ms;
    learn_request_i <= learn;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  // Drain all requests, then write one register over the APB port
  task automatic program_register(input logic idx, input logic [31:0] value);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_MIN_SAMPLES) cur_min = value[7:0];
    else cur_timeout = value[15:0];
  endtask

  // Extremes, every opcode, wrapping time, button decode and learn cases
  task automatic run_directed();
    send_request(OP_READ, 2'd0, 32'd0, 32'd0, 1'b0);
    send_request(OP_RX,   2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 1'b0);
    send_request(OP_RX,   2'd0, 32'hFFFF_FFFF, 32'hFFFF_FFF8, 1'b0);
    send_request(OP_RX,   2'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_request(OP_READ, 2'd0, 32'd0, 32'd0, 1'b0);
    // timeout across the time wrap: equal is not expired, one more is
    send_request(OP_RX,   2'd1, 32'h0000_0001, 32'hFFFF_FFF0, 1'b0);
    send_request(OP_TICK, 2'd1, 32'd0, 32'h0000_0040, 1'b0);
    send_request(OP_TICK, 2'd1, 32'd0, 32'h0000_0041, 1'b0);
    send_request(OP_READ, 2'd1, 32'd0, 32'd0, 1'b0);
    // an unread button event gets replaced
    send_request(OP_RX,   2'd2, 32'hA5A5_5A52, 32'h0000_0100, 1'b0);
    send_request(OP_TICK, 2'd2, 32'd0, 32'h0000_0200, 1'b0);
    send_request(OP_RX,   2'd2, 32'h0000_0004, 32'h0000_0300, 1'b0);
    send_request(OP_TICK, 2'd2, 32'd0, 32'h0000_0400, 1'b0);
    send_request(OP_READ, 2'd2, 32'd0, 32'd0, 1'b0);
    send_request(OP_RX,   2'd3, 32'h0000_0008, 32'h0000_0500, 1'b0);
    send_request(OP_TICK, 2'd3, 32'd0, 32'h0000_0600, 1'b0);
    send_request(OP_READ, 2'd3, 32'd0, 32'd0, 1'b0);
    send_request(OP_RX,   2'd3, 32'h7FFF_FFF0, 32'h0000_0700, 1'b0);
    send_request(OP_TICK, 2'd3, 32'd0, 32'h0000_0800, 1'b0);
    send_request(OP_READ, 2'd3, 32'd0, 32'd0, 1'b0);
    // learn mode: count cleared, ticks ignored, mismatch drops learn
    send_request(OP_RX,   2'd1, 32'h0000_0012, 32'h0000_0900, 1'b0);
    send_request(OP_MODE, 2'd1, 32'd0, 32'd0, 1'b1);
    send_request(OP_TICK, 2'd1, 32'd0, 32'h0001_0000, 1'b0);
    send_request(OP_RX,   2'd1, 32'h0000_0013, 32'h0001_0001, 1'b0);
    send_request(OP_READ, 2'd1, 32'd0, 32'd0, 1'b0);
    send_request(OP_MODE, 2'd0, 32'd0, 32'd0, 1'b0);
  endtask

  // One random stretch: mostly a well-formed press, else mixed traffic or noise
  task automatic random_sequence(input logic long_burst);
    logic [1:0]  ch;
    logic [31:0] code;
    logic [31:0] delta;
    logic        learning;
    int          kind;
    int          reps;
    ch       = 2'($urandom_range(3));
    kind     = $urandom_range(99);
    code     = $urandom;
    learning = 1'b0;
    case ($urandom_range(4))
      0: code[3:0] = 4'h1;
      1: code[3:0] = 4'h2;
      2: code[3:0] = 4'h4;
      3: code[3:0] = 4'h8;
      default: ;
    endcase
    if (long_burst) reps = 258 + $urandom_range(4);
    else if ($urandom_range(4) == 0 && cur_min < 40) reps = cur_min + 1 + $urandom_range(2);
    else reps = 1 + $urandom_range(5);

    if (long_burst || kind < 60) begin
      if ($urandom_range(2) == 0) begin
        learning = 1'b1;
        send_request(OP_MODE, ch, $urandom, $urandom, 1'b1);
      end
      repeat (reps) begin
        ms_now = ms_now + $urandom_range(1, 30);
        send_request(OP_RX, ch, code, ms_now, 1'b0);
      end
      if ($urandom_range(5) == 0) begin
        ms_now = ms_now + 1;
        send_request(OP_RX, ch, code ^ (32'd1 << $urandom_range(31)), ms_now, 1'b0);
      end
      if (learning && $urandom_range(1) == 0)
        send_request(OP_MODE, ch, $urandom, $urandom, 1'b0);
      repeat (1 + $urandom_range(2)) begin
        if ($urandom_range(2) == 0) delta = $urandom_range(cur_timeout);
        else delta = {16'd0, cur_timeout} + $urandom_range(2);
        ms_now = ms_now + delta;
        send_request(OP_TICK, ch, $urandom, ms_now, 1'($urandom_range(1)));
      end
      send_request(OP_READ, ch, $urandom, $urandom, 1'($urandom_range(1)));
    end else if (kind < 85) begin
      // mixed traffic on all channels around the timeout
      repeat (1 + $urandom_range(7)) begin
        ms_now = ms_now + $urandom_range({16'd0, cur_timeout} + 2);
        send_request(opcode_e'($urandom_range(3)), 2'($urandom_range(3)),
                     ($urandom_range(9) < 7) ? code : $urandom, ms_now,
                     1'($urandom_range(1)));
      end
    end else begin
      repeat (1 + $urandom_range(3))
        send_request(opcode_e'($urandom_range(3)), 2'($urandom_range(3)),
                     $urandom, $urandom, 1'($urandom_range(1)));
    end
  endtask

  initial begin
    int          target;
    logic [7:0]  phase_min     [4];
    logic [15:0] phase_timeout [4];
    int          phase_gap     [4];
    int          phase_stall   [4];
    phase_min     = '{8'd2, 8'd255, 8'd0, 8'd20};
    phase_timeout = '{16'd15, 16'hFFFF, 16'd0, 16'd80};
    phase_gap     = '{0, 45, 0, 6};
    phase_stall   = '{0, 0, 45, 6};

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    run_directed();

    // Random phases, each with its own settings and idling pattern
    for (int p = 0; p < 4; p++) begin
      program_register(REG_MIN_SAMPLES, {24'd0, phase_min[p]});
      program_register(REG_RELEASE_TIMEOUT, {16'd0, phase_timeout[p]});
      gap_pct   = phase_gap[p];
      stall_pct = phase_stall[p];
      target    = sent + PHASE_ITEMS;
      random_sequence(p == 1);
      while (sent < target) random_sequence(1'b0);
    end

    // Drain, then give stray results time to show
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("rf_remote_code_qualifier: match");
    end else begin
      $display("rf_remote_code_qualifier: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
design/rfq_pkg.sv
design/rfq_in_stage.sv
design/rfq_core.sv
design/rf_remote_code_qualifier.sv
test/rfq_checker.sv
test/tb_rf_remote_code_qualifier.sv
